FILE: rtl/primitive_assembly_engine_defines.svh
`ifndef PRIMITIVE_ASSEMBLY_ENGINE_DEFINES_SVH
`define PRIMITIVE_ASSEMBLY_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PAE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PAE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pae_pkg.sv
// ----------------------------------------------------------------------------
// pae_pkg
// types, codes and sizes shared by the primitive assembly engine modules
// ----------------------------------------------------------------------------
`default_nettype none

package pae_pkg;

	localparam int HANDLE_BITS = 16;
	localparam int SLOT_COUNT  = 4;
	localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
	localparam int FILL_W      = 3;
	localparam int PHASE_W     = 3;
	localparam int SKIP_W      = 2;
	localparam int CMD_W       = 2;
	localparam int PRIM_W      = 3;
	localparam int KIND_W      = 2;
	localparam int CULL_W      = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// commands
	localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_VERTEX = 2'd1;
	localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

	// primitive types of a begin draw
	localparam logic [PRIM_W-1:0] PRIM_POINTS = 3'd0;
	localparam logic [PRIM_W-1:0] PRIM_LINES  = 3'd1;
	localparam logic [PRIM_W-1:0] PRIM_LSTRIP = 3'd2;
	localparam logic [PRIM_W-1:0] PRIM_TRIS   = 3'd3;
	localparam logic [PRIM_W-1:0] PRIM_TSTRIP = 3'd4;
	localparam logic [PRIM_W-1:0] PRIM_FAN    = 3'd5;
	localparam logic [PRIM_W-1:0] PRIM_RECTS  = 3'd6;
	localparam logic [PRIM_W-1:0] PRIM_KEEP   = 3'd7;

	// emitted primitive kinds
	localparam logic [KIND_W-1:0] KIND_POINT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TRI   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RECT  = 2'd3;

	// cull modes, anything with the high bit set means culling off
	localparam logic [CULL_W-1:0] CULL_CW  = 2'd0;
	localparam logic [CULL_W-1:0] CULL_OFF = 2'd2;

	localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd5;

	typedef logic [HANDLE_BITS-1:0] handle_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [PRIM_W-1:0] draw_type;
		handle_t           vertex_handle;
		logic              outside;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] prim_kind;
		handle_t           vert_a;
		handle_t           vert_b;
		handle_t           vert_c;
		handle_t           provoking;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] prim_kind;
		handle_t           vert_a;
		handle_t           vert_b;
		handle_t           vert_c;
		handle_t           provoking;
	} prim_res_t;

	// one or two primitives caused by one input transaction
	typedef struct packed {
		logic      two;
		prim_res_t r0;
		prim_res_t r1;
	} job_t;

endpackage

`default_nettype wire

FILE: rtl/pae_front.sv
// ----------------------------------------------------------------------------
// pae_front
// accepts commands, tracks draw state and the vertex slots, builds jobs
// ----------------------------------------------------------------------------
`default_nettype none

module pae_front
	import pae_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [CULL_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              job_valid,
	input  logic              job_ready,
	output job_t              job
);

	function automatic prim_res_t mk_res(logic [KIND_W-1:0] kind, handle_t a, handle_t b,
		handle_t c, handle_t p);
		prim_res_t r;
		r.prim_kind = kind;
		r.vert_a    = a;
		r.vert_b    = b;
		r.vert_c    = c;
		r.provoking = p;
		return r;
	endfunction

	function automatic job_t mk_tri(logic [CULL_W-1:0] cull, logic rev, handle_t a,
		handle_t b, handle_t c, handle_t p);
		job_t j;
		j = '0;
		if (cull[1]) begin
			j.two = 1'b1;
			j.r0  = mk_res(KIND_TRI, a, b, c, p);
			j.r1  = mk_res(KIND_TRI, c, b, a, p);
		end else if (rev) begin
			j.r0 = mk_res(KIND_TRI, c, b, a, p);
		end else begin
			j.r0 = mk_res(KIND_TRI, a, b, c, p);
		end
		return j;
	endfunction

	// slot written by a strip or fan vertex at a given phase
	function automatic logic [SLOT_IDX_W-1:0] strip_slot(logic [PRIM_W-1:0] prim,
		logic [PHASE_W-1:0] pre);
		logic [SLOT_IDX_W-1:0] s;
		s = '0;
		case (prim)
			PRIM_LSTRIP: s = SLOT_IDX_W'(pre[0]);
			PRIM_TSTRIP: begin
				case (pre)
					3'd1, 3'd4: s = SLOT_IDX_W'(1);
					3'd2, 3'd5: s = SLOT_IDX_W'(2);
					default:    s = '0;
				endcase
			end
			default: s = pre[0] ? SLOT_IDX_W'(1) : SLOT_IDX_W'(2);
		endcase
		return s;
	endfunction

	handle_t               slots_q [SLOT_COUNT];
	handle_t               slots_v [SLOT_COUNT];
	logic [FILL_W-1:0]     fill_q, fill_n, fill_inc, rect_fill, eff_fill, need;
	logic [PHASE_W-1:0]    phase_q, phase_n;
	logic [SKIP_W-1:0]     skip_q, skip_n;
	logic [PRIM_W-1:0]     prim_q, prim_n, eff_prim;
	logic                  opend_q, opend_n, dropn_q, dropn_n, dead_q, dead_n;
	logic [CULL_W-1:0]     cull_q;
	logic                  accept, emit, is_list, is_strip, wr_en, pend_any;
	logic [SLOT_IDX_W-1:0] wr_idx, s_idx;
	handle_t               prov;

	assign in_ready  = job_ready;
	assign accept    = in_valid && in_ready;
	assign job_valid = accept && emit;

	assign is_list  = (prim_q inside {PRIM_POINTS, PRIM_LINES, PRIM_TRIS});
	assign is_strip = (prim_q inside {PRIM_LSTRIP, PRIM_TSTRIP, PRIM_FAN});
	assign fill_inc = fill_q + 1'b1;
	assign pend_any = opend_q || in_data.outside;
	assign s_idx    = strip_slot(prim_q, phase_q);
	assign eff_prim = (in_data.draw_type != PRIM_KEEP) ? in_data.draw_type : prim_q;
	assign eff_fill = (in_data.draw_type != PRIM_KEEP) ? '0 : fill_q;
	assign need     = (prim_q == PRIM_POINTS) ? 3'd1 : ((prim_q == PRIM_LINES) ? 3'd2 : 3'd3);

	// slot write of a vertex
	always_comb begin
		wr_en  = (in_data.command == CMD_VERTEX) && !dead_q &&
			(is_list || (prim_q == PRIM_RECTS && !dropn_q) || is_strip);
		wr_idx = fill_q[SLOT_IDX_W-1:0];
		if (is_strip) begin
			wr_idx = (prim_q == PRIM_FAN && fill_q == '0) ? '0 : s_idx;
		end
	end

	// slots as seen after this transaction's write
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slots_v[i] = (wr_en && wr_idx == SLOT_IDX_W'(i)) ? in_data.vertex_handle : slots_q[i];
		end
	end

	always_comb begin
		case (s_idx)
			2'd0:    prov = slots_v[0];
			2'd1:    prov = slots_v[1];
			2'd2:    prov = slots_v[2];
			default: prov = slots_v[3];
		endcase
	end

	always_comb begin
		fill_n    = fill_q;
		phase_n   = phase_q;
		skip_n    = skip_q;
		prim_n    = prim_q;
		opend_n   = opend_q;
		dropn_n   = dropn_q;
		dead_n    = dead_q;
		rect_fill = fill_inc;
		emit      = 1'b0;
		job       = '0;
		case (in_data.command)
			CMD_BEGIN: begin
				prim_n  = eff_prim;
				fill_n  = eff_fill;
				if (in_data.draw_type != PRIM_KEEP) begin
					phase_n = '0;
				end
				opend_n = 1'b0;
				dropn_n = 1'b0;
				dead_n  = 1'b0;
				case (eff_prim)
					PRIM_LSTRIP: skip_n = (eff_fill == '0) ? 2'd1 : 2'd0;
					PRIM_TSTRIP: skip_n = (eff_fill >= 3'd2) ? 2'd0 : SKIP_W'(3'd2 - eff_fill);
					PRIM_FAN:    skip_n = (eff_fill <= 3'd1) ? 2'd1 : 2'd0;
					default:     skip_n = '0;
				endcase
			end
			CMD_VERTEX: begin
				if (!dead_q && is_list) begin
					if (fill_inc < need) begin
						fill_n  = fill_inc;
						opend_n = pend_any;
					end else begin
						fill_n  = '0;
						opend_n = 1'b0;
						emit    = !pend_any;
						case (prim_q)
							PRIM_POINTS: job.r0 = mk_res(KIND_POINT, slots_v[0], '0, '0, slots_v[0]);
							PRIM_LINES:  job.r0 = mk_res(KIND_LINE, slots_v[0], slots_v[1], '0,
								slots_v[1]);
							default:     job = mk_tri(cull_q, cull_q == CULL_CW, slots_v[0],
								slots_v[1], slots_v[2], slots_v[2]);
						endcase
					end
				end else if (!dead_q && prim_q == PRIM_RECTS) begin
					if (dropn_q) begin
						dropn_n = 1'b0;
					end else begin
						if (in_data.outside) begin
							if (fill_inc[0]) begin
								dropn_n   = 1'b1;
								rect_fill = fill_inc - 3'd1;
							end else begin
								rect_fill = fill_inc - 3'd2;
							end
						end
						if (rect_fill == 3'd4) begin
							fill_n  = '0;
							emit    = 1'b1;
							job.two = 1'b1;
							job.r0  = mk_res(KIND_RECT, slots_v[0], slots_v[1], '0, slots_v[1]);
							job.r1  = mk_res(KIND_RECT, slots_v[2], slots_v[3], '0, slots_v[3]);
						end else begin
							fill_n = rect_fill;
						end
					end
				end else if (!dead_q && is_strip) begin
					if (prim_q == PRIM_FAN && fill_q == '0) begin
						// fan centre
						fill_n  = 3'd1;
						phase_n = 3'd1;
						dead_n  = in_data.outside;
					end else begin
						phase_n = (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
						fill_n  = (fill_q < 3'd2) ? fill_inc : fill_q;
						if (in_data.outside) begin
							skip_n = 2'd2;
						end else if (skip_q != '0) begin
							skip_n = skip_q - 1'b1;
						end else begin
							emit = 1'b1;
							if (prim_q == PRIM_LSTRIP) begin
								job.r0 = mk_res(KIND_LINE, phase_q[0] ? slots_v[0] : slots_v[1],
									phase_q[0] ? slots_v[1] : slots_v[0], '0, prov);
							end else begin
								job = mk_tri(cull_q, (cull_q == CULL_CW) != phase_q[0],
									slots_v[0], slots_v[1], slots_v[2], prov);
							end
						end
					end
				end
			end
			CMD_END: begin
				if (prim_q == PRIM_RECTS && fill_q >= 3'd2) begin
					emit   = 1'b1;
					job.r0 = mk_res(KIND_RECT, slots_v[0], slots_v[1], '0, slots_v[1]);
					fill_n = fill_q - 3'd2;
				end
				dropn_n = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			phase_q <= '0;
			skip_q  <= '0;
			prim_q  <= PRIM_POINTS;
			opend_q <= 1'b0;
			dropn_q <= 1'b0;
			dead_q  <= 1'b0;
			cull_q  <= CULL_OFF;
		end else begin
			if (cfg_valid) begin
				cull_q <= cfg_data;
			end
			if (accept) begin
				fill_q  <= fill_n;
				phase_q <= phase_n;
				skip_q  <= skip_n;
				prim_q  <= prim_n;
				opend_q <= opend_n;
				dropn_q <= dropn_n;
				dead_q  <= dead_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			slots_q[wr_idx] <= in_data.vertex_handle;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pae_queue.sv
// ----------------------------------------------------------------------------
// pae_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module pae_queue
	import pae_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_data
);

	function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push, pop;

	assign push_ready = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (pop) begin
				rd_q <= next_ptr(rd_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pae_back.sv
// ----------------------------------------------------------------------------
// pae_back
// splits jobs into result transactions behind an output register
// ----------------------------------------------------------------------------
`default_nettype none

module pae_back
	import pae_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_ready,
	input  job_t      job,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	function automatic out_item_t to_out(prim_res_t r, logic last);
		out_item_t o;
		o.prim_kind = r.prim_kind;
		o.vert_a    = r.vert_a;
		o.vert_b    = r.vert_b;
		o.vert_c    = r.vert_c;
		o.provoking = r.provoking;
		o.last      = last;
		return o;
	endfunction

	out_item_t out_q;
	prim_res_t sec_q;
	logic      out_valid_q, sec_pend_q, adv;

	assign adv       = !out_valid_q || out_ready;
	assign job_ready = adv && !sec_pend_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_pend_q  <= 1'b0;
		end else if (adv) begin
			if (sec_pend_q) begin
				out_valid_q <= 1'b1;
				sec_pend_q  <= 1'b0;
			end else if (job_valid) begin
				out_valid_q <= 1'b1;
				sec_pend_q  <= job.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sec_pend_q) begin
				out_q <= to_out(sec_q, 1'b1);
			end else if (job_valid) begin
				out_q <= to_out(job.r0, !job.two);
				sec_q <= job.r1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/primitive_assembly_engine.sv
// ----------------------------------------------------------------------------
// primitive_assembly_engine
// the first result of a transaction passes the job queue and then the output
// register before it is presented, when the queue and the output register are empty
// throughput: one input transaction per cycle while the job queue has room
// the output register gives one result per cycle while out_ready is high, a
// triangle with both windings or a rectangle pair gives two results
// reset clears the draw state but not the vertex slots and sets cull_mode to off, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none
`include "primitive_assembly_engine_defines.svh"

module primitive_assembly_engine
	import pae_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration write: cull mode
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CULL_W-1:0] cfg_data,
	// command and vertex stream
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	// assembled primitives
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data
);

	// front to queue
	logic job_valid, job_ready;
	job_t job;
	// queue to back
	logic q_valid, q_ready;
	job_t q_job;

	// the cull register takes a write in any cycle
	assign cfg_ready = 1'b1;

	// front: decodes commands, owns the vertex slots and strip counters,
	// and turns each transaction into zero, one or two primitives
	pae_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	// decoupling queue, lets the front keep taking vertices while the
	// back still drains a two-primitive job
	pae_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_valid),
		.push_ready (job_ready),
		.push_data  (job),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_job)
	);

	// back: one result transaction per cycle from the output register while
	// out_ready is high, last marks the final primitive of a job
	pae_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job       (q_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a job is only produced when the queue has room for it
	`PAE_ASSERT_NOW(a_push_room, job_valid, job_ready, "job pushed into a full queue")

	// the second primitive of a pair follows its first with no gap
	`PAE_ASSERT_NEXT(a_pair_follows, out_valid && out_ready && !out_data.last,
		out_valid && out_data.last, "second primitive of a pair not presented")

	// only triangles carry a third vertex
	`PAE_ASSERT_NOW(a_vert_c_zero, out_valid && out_data.prim_kind != KIND_TRI,
		out_data.vert_c == '0, "third vertex set on a non-triangle")

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for primitive_assembly_engine
// feeds draw commands and vertex handles through the valid/ready stream,
// rebuilds the expected points, lines, triangles and rectangles with its own
// assembly predictor, and checks each result transaction field by field
// across all cull modes and three pacing profiles
// ----------------------------------------------------------------------------
module testbench;
	import pae_pkg::*;

	// codes the package does not name
	localparam logic [CMD_W-1:0]  CMD_NONE    = 2'd3;
	localparam logic [CULL_W-1:0] CULL_CCW    = 2'd1;
	localparam logic [CULL_W-1:0] CULL_OFF_HI = 2'd3;

	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int TAIL_CYCLES     = 8;
	// cycles without any transaction on any channel before giving up
	localparam int QUIET_LIMIT     = 2000;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CULL_W-1:0] cfg_data  = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_item_t          in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_data;

	primitive_assembly_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// ------------------------------------------------------------------
	// assembly predictor state, mirrors the block's draw state
	// ------------------------------------------------------------------
	handle_t            slots [SLOT_COUNT];
	logic [FILL_W-1:0]  fill_cnt;
	logic [PHASE_W-1:0] strip_pos;
	logic [SKIP_W-1:0]  skip_cnt;
	logic [PRIM_W-1:0]  draw_prim;
	logic               outside_seen;
	logic               drop_vert;
	logic               draw_killed;
	logic [CULL_W-1:0]  cull_sel;

	out_item_t new_prims [$];       // primitives caused by the current transaction
	out_item_t expected_prims [$];  // primitives still owed by the block
	in_item_t  pending_cmds [$];    // stream transactions not yet driven

	int   errors       = 0;
	int   items_sent   = 0;
	int   prims_seen   = 0;
	int   quiet_cycles = 0;
	int   calm_left    = 0;
	int   snd_idle     = 0;
	int   rcv_idle     = 0;
	logic in_acc       = 1'b0;

	function automatic void emit(logic [KIND_W-1:0] kind, handle_t a, handle_t b, handle_t c,
			handle_t p);
		out_item_t r;
		r.prim_kind = kind;
		r.vert_a    = a;
		r.vert_b    = b;
		r.vert_c    = c;
		r.provoking = p;
		r.last      = 1'b0;
		new_prims.push_back(r);
	endfunction

	// culling off (either high-bit mode) gives both windings
	function automatic void emit_tri(logic reverse, handle_t p);
		if (cull_sel[1]) begin
			emit(KIND_TRI, slots[0], slots[1], slots[2], p);
			emit(KIND_TRI, slots[2], slots[1], slots[0], p);
		end else if (reverse) begin
			emit(KIND_TRI, slots[2], slots[1], slots[0], p);
		end else begin
			emit(KIND_TRI, slots[0], slots[1], slots[2], p);
		end
	endfunction

	function automatic void open_draw(logic [PRIM_W-1:0] ptype);
		if (ptype != PRIM_KEEP) begin
			draw_prim = ptype;
			fill_cnt  = '0;
			strip_pos = '0;
		end
		outside_seen = 1'b0;
		drop_vert    = 1'b0;
		draw_killed  = 1'b0;
		// vertices a strip or fan still needs before it can emit
		case (draw_prim)
			PRIM_LSTRIP: skip_cnt = (fill_cnt == 0) ? 2'd1 : 2'd0;
			PRIM_TSTRIP: skip_cnt = (fill_cnt == 0) ? 2'd2 : (fill_cnt == 1) ? 2'd1 : 2'd0;
			PRIM_FAN:    skip_cnt = (fill_cnt <= 1) ? 2'd1 : 2'd0;
			default:     skip_cnt = '0;
		endcase
	endfunction

	// points, lines and triangle lists
	function automatic void list_vertex(handle_t h, logic outside);
		logic [FILL_W-1:0] need;
		need = (draw_prim == PRIM_POINTS) ? 3'd1 : (draw_prim == PRIM_LINES) ? 3'd2 : 3'd3;
		slots[fill_cnt[1:0]] = h;
		fill_cnt = fill_cnt + 1'b1;
		if (outside) begin
			outside_seen = 1'b1;
		end
		if (fill_cnt >= need) begin
			fill_cnt = '0;
			if (outside_seen) begin
				outside_seen = 1'b0;
			end else if (need == 3'd1) begin
				emit(KIND_POINT, slots[0], '0, '0, slots[0]);
			end else if (need == 3'd2) begin
				emit(KIND_LINE, slots[0], slots[1], '0, slots[1]);
			end else begin
				emit_tri(cull_sel == CULL_CW, slots[2]);
			end
		end
	endfunction

	function automatic void rect_vertex(handle_t h, logic outside);
		if (drop_vert) begin
			drop_vert = 1'b0;
		end else begin
			slots[fill_cnt[1:0]] = h;
			fill_cnt = fill_cnt + 1'b1;
			if (outside) begin
				if (fill_cnt[0]) begin
					drop_vert = 1'b1;
					fill_cnt  = fill_cnt - 1'b1;
				end else begin
					fill_cnt = fill_cnt - 3'd2;
				end
			end
			if (fill_cnt == 3'd4) begin
				emit(KIND_RECT, slots[0], slots[1], '0, slots[1]);
				emit(KIND_RECT, slots[2], slots[3], '0, slots[3]);
				fill_cnt = '0;
			end
		end
	endfunction

	// line strips, triangle strips and fans
	function automatic void strip_vertex(handle_t h, logic outside);
		logic [PHASE_W-1:0] pre;
		logic [PHASE_W-1:0] mod3;
		logic [1:0]         s;
		pre  = strip_pos;
		mod3 = pre % 3'd3;
		if (draw_prim == PRIM_FAN && fill_cnt == 0) begin
			// fan centre, an outside centre kills the rest of the draw
			slots[0]  = h;
			fill_cnt  = 3'd1;
			strip_pos = 3'd1;
			if (outside) begin
				draw_killed = 1'b1;
			end
		end else begin
			if (draw_prim == PRIM_LSTRIP) begin
				s = {1'b0, pre[0]};
			end else if (draw_prim == PRIM_TSTRIP) begin
				s = mod3[1:0];
			end else begin
				s = pre[0] ? 2'd1 : 2'd2;
			end
			slots[s]  = h;
			strip_pos = (pre == PHASE_LAST) ? '0 : pre + 1'b1;
			if (fill_cnt < 3'd2) begin
				fill_cnt = fill_cnt + 1'b1;
			end
			if (outside) begin
				skip_cnt = 2'd2;
			end else if (skip_cnt != 0) begin
				skip_cnt = skip_cnt - 1'b1;
			end else if (draw_prim == PRIM_LSTRIP) begin
				emit(KIND_LINE, slots[{1'b0, ~pre[0]}], slots[s], '0, slots[s]);
			end else begin
				emit_tri((cull_sel == CULL_CW) != pre[0], slots[s]);
			end
		end
	endfunction

	// works out every primitive one accepted stream transaction causes
	function automatic void assemble_item(in_item_t it);
		out_item_t r;
		new_prims.delete();
		case (it.command)
			CMD_BEGIN: open_draw(it.draw_type);
			CMD_VERTEX: begin
				if (!draw_killed) begin
					case (draw_prim)
						PRIM_POINTS, PRIM_LINES, PRIM_TRIS:
							list_vertex(it.vertex_handle, it.outside);
						PRIM_RECTS:
							rect_vertex(it.vertex_handle, it.outside);
						PRIM_LSTRIP, PRIM_TSTRIP, PRIM_FAN:
							strip_vertex(it.vertex_handle, it.outside);
						default: ;
					endcase
				end
			end
			CMD_END: begin
				// a rectangle still held goes out at draw end
				if (draw_prim == PRIM_RECTS && fill_cnt >= 3'd2) begin
					emit(KIND_RECT, slots[0], slots[1], '0, slots[1]);
					fill_cnt = fill_cnt - 3'd2;
				end
				drop_vert = 1'b0;
			end
			default: ;
		endcase
		for (int i = 0; i < new_prims.size(); i++) begin
			r      = new_prims[i];
			r.last = (i == new_prims.size() - 1);
			expected_prims.push_back(r);
		end
	endfunction

	task automatic check_prim(out_item_t got);
		out_item_t want;
		prims_seen++;
		if (expected_prims.size() == 0) begin
			$error("unexpected primitive: kind %0d a %h b %h c %h", got.prim_kind, got.vert_a,
				got.vert_b, got.vert_c);
			errors++;
		end else begin
			want = expected_prims.pop_front();
			if (got.prim_kind !== want.prim_kind) begin
				$error("prim_kind mismatch: expected %0d, got %0d", want.prim_kind, got.prim_kind);
				errors++;
			end
			if (got.vert_a !== want.vert_a) begin
				$error("vert_a mismatch: expected %h, got %h", want.vert_a, got.vert_a);
				errors++;
			end
			if (got.vert_b !== want.vert_b) begin
				$error("vert_b mismatch: expected %h, got %h", want.vert_b, got.vert_b);
				errors++;
			end
			if (got.vert_c !== want.vert_c) begin
				$error("vert_c mismatch: expected %h, got %h", want.vert_c, got.vert_c);
				errors++;
			end
			if (got.provoking !== want.provoking) begin
				$error("provoking mismatch: expected %h, got %h", want.provoking, got.provoking);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last mismatch: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus construction
	// ------------------------------------------------------------------
	function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic [PRIM_W-1:0] ptype,
			handle_t h, logic outside);
		in_item_t it;
		it.command       = cmd;
		it.draw_type     = ptype;
		it.vertex_handle = h;
		it.outside       = outside;
		pending_cmds.push_back(it);
	endfunction

	// hand-picked sequences: extremes of the handle, rectangle pair
	// handling, keep-previous, dead fan, ignored command, list drops
	task automatic queue_directed();
		// vertex with no draw open yet is a point
		queue_cmd(CMD_VERTEX, PRIM_KEEP, 16'h1234, 1'b0);
		// rectangles fill all four slots, then the pair special cases
		queue_cmd(CMD_BEGIN, PRIM_RECTS, 16'hFFFF, 1'b1);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h0000, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_KEEP, 16'hFFFF, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_LINES, 16'h0001, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_FAN, 16'h8000, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h00AA, 1'b0);
		// outside second of a pair forgets the pair
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h00BB, 1'b1);
		// outside first of a pair, and the next vertex is swallowed
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h00CC, 1'b1);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h00DD, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h00EE, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h00FF, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h0ABC, 1'b0);
		// odd remainder: end emits one rectangle and keeps a vertex
		queue_cmd(CMD_END, PRIM_TRIS, 16'h5555, 1'b1);
		queue_cmd(CMD_BEGIN, PRIM_KEEP, 16'hAAAA, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h0DEF, 1'b0);
		queue_cmd(CMD_END, PRIM_POINTS, 16'h0000, 1'b0);
		// fan with an outside centre, the rest of the draw is dead
		queue_cmd(CMD_BEGIN, PRIM_FAN, 16'h0000, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h7FFF, 1'b1);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h4321, 1'b0);
		// reserved command does nothing
		queue_cmd(CMD_NONE, PRIM_RECTS, 16'hFFFF, 1'b1);
		// triangle list: outside vertex drops the triangle, the next one passes
		queue_cmd(CMD_BEGIN, PRIM_TRIS, 16'h0000, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h0101, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h0202, 1'b1);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h0303, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'hFFFF, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'h0000, 1'b0);
		queue_cmd(CMD_VERTEX, PRIM_POINTS, 16'hBEEF, 1'b0);
	endtask

	// one random draw: begin, a run of vertices, usually an end, with noise
	task automatic queue_random_draw(inout int made);
		int                nv;
		logic [PRIM_W-1:0] ptype;
		ptype = PRIM_W'($urandom);
		if ($urandom_range(19) == 0) begin
			queue_cmd(CMD_NONE, PRIM_W'($urandom), HANDLE_BITS'($urandom), 1'($urandom));
		end
		if ($urandom_range(29) == 0) begin
			// stray vertex or end outside a proper draw
			queue_cmd($urandom_range(1) ? CMD_VERTEX : CMD_END, PRIM_W'($urandom),
				HANDLE_BITS'($urandom), 1'($urandom));
			made++;
		end
		queue_cmd(CMD_BEGIN, ptype, HANDLE_BITS'($urandom), 1'($urandom));
		made++;
		nv = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(9);
		repeat (nv) begin
			queue_cmd(CMD_VERTEX, PRIM_W'($urandom), HANDLE_BITS'($urandom),
				$urandom_range(99) < 9);
			made++;
		end
		// leaving out the end lets a keep-previous draw continue the primitive
		if ($urandom_range(6) != 0) begin
			queue_cmd(CMD_END, PRIM_W'($urandom), HANDLE_BITS'($urandom), 1'($urandom));
			made++;
		end
	endtask

	// cull register write, only issued while the block is idle
	task automatic write_cull(logic [CULL_W-1:0] mode);
		@(negedge clk);
		cfg_data  <= mode;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (cfg_ready !== 1'b1) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every queued transaction went in and every primitive came out
	task automatic drain();
		@(posedge clk);
		while (pending_cmds.size() != 0 || in_valid || expected_prims.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// stream driver: a new transaction only once the held one is taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || in_acc) begin
			if (pending_cmds.size() != 0 && (calm_left != 0 || $urandom_range(99) >= snd_idle)) begin
				in_data  <= pending_cmds.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		out_ready <= (calm_left != 0) || ($urandom_range(99) >= rcv_idle);
	end

	// ------------------------------------------------------------------
	// monitor: predicts on accepted stream transactions, checks results
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		in_acc = arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				cull_sel = cfg_data;
			end
			if (in_acc) begin
				assemble_item(in_data);
				items_sent++;
			end
			if (out_valid && out_ready) begin
				check_prim(out_data);
			end
		end
		// occasional stretches where neither side holds back
		if (calm_left != 0) begin
			calm_left--;
		end else if ($urandom_range(47) == 0) begin
			calm_left = $urandom_range(40, 10);
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	logic [CULL_W-1:0] cull_plan [PHASES] = '{CULL_OFF, CULL_CW, CULL_CCW, CULL_OFF_HI,
		CULL_CW, CULL_OFF};

	initial begin
		int made;
		// predictor starts in the reset state
		foreach (slots[i]) begin
			slots[i] = '0;
		end
		fill_cnt     = '0;
		strip_pos    = '0;
		skip_cnt     = '0;
		draw_prim    = PRIM_POINTS;
		outside_seen = 1'b0;
		drop_vert    = 1'b0;
		draw_killed  = 1'b0;
		cull_sel     = CULL_OFF;

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			// slow sender with a slower receiver, then the reverse, then full rate
			if (ph < 2) begin
				snd_idle = 38;
				rcv_idle = 80;
			end else if (ph < 4) begin
				snd_idle = 80;
				rcv_idle = 38;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			write_cull(cull_plan[ph]);
			if (ph == 0) begin
				queue_directed();
			end
			made = 0;
			while (made < ITEMS_PER_PHASE) begin
				queue_random_draw(made);
			end
			drain();
		end

		$display("run covered %0d stream transactions and %0d primitives", items_sent,
			prims_seen);
		$display("under all four cull settings and three pacing profiles");
		if (errors == 0 && expected_prims.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pae_pkg.sv
rtl/pae_front.sv
rtl/pae_queue.sv
rtl/pae_back.sv
rtl/primitive_assembly_engine.sv
dv/testbench.sv
